// ----- hw/rtl/bpmpos_pkg.sv -----
// bpmpos_pkg: widths, configuration layout, register indexes and item types
// shared by every module of the stripline beam position block
// no dependencies
package bpmpos_pkg;

	// sample width of the digitizer
	localparam int ADC_BITS = 13;

	// stream payload layout
	localparam int IN_W        = 4 * ADC_BITS;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PED_W      = 13;

	localparam logic [CFG_IDX_W-1:0] REG_PED_XP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PED_XM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PED_YP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PED_YM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KAPPA   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEN_X = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEN_Y = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd7;

	// front arithmetic widths
	localparam int SMP_W  = ADC_BITS + 1;   // pedestal-subtracted sample
	localparam int DIF_W  = ADC_BITS + 2;   // axis difference and sum
	localparam int MAG_W  = ADC_BITS + 1;   // magnitude of difference or sum
	localparam int PROD_W = 16 + MAG_W;     // kappa times difference

	// divider widths: dividend 32*prod + |sum|, padded to two bits per stage
	localparam int NUM_W      = 2 * ((PROD_W + 7) / 2);
	localparam int DEN_W      = MAG_W + 1;
	localparam int DIV_STAGES = NUM_W / 2;

	// back arithmetic widths
	localparam int XR_W  = NUM_W + 1;       // signed rotated coordinate
	localparam int SUM_W = NUM_W + 2;       // xr -/+ yr
	localparam int PA_W  = SUM_W + 17;      // times attenuation
	localparam int TC_W  = 25;              // clamped Q.12 value, saturates beyond
	localparam int MS_W  = TC_W + 17;       // times 1/sqrt(2)
	localparam int T2_W  = MS_W - 16;
	localparam int WO_W  = T2_W + 1;        // with offset applied
	localparam int TC_MAX = 2 ** (TC_W - 1) - 1;
	localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

	// queue between front and back
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 2 ** FIFO_AW;

	typedef struct packed {
		logic [PED_W-1:0] ped_xp;
		logic [PED_W-1:0] ped_xm;
		logic [PED_W-1:0] ped_yp;
		logic [PED_W-1:0] ped_ym;
		logic [15:0]      kappa;
		logic [15:0]      atten_x;
		logic [15:0]      atten_y;
		logic [31:0]      offset_pair;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		ped_xp:      13'd568,
		ped_xm:      13'd518,
		ped_yp:      13'd427,
		ped_ym:      13'd448,
		kappa:       16'd4831,
		atten_x:     16'd18186,
		atten_y:     16'd17531,
		offset_pair: 32'd11337608
	};

	// one axis as classified by the front
	typedef struct packed {
		logic [PROD_W-1:0] prod;   // kappa * |plus - minus|
		logic [MAG_W-1:0]  mag;    // |plus + minus|
		logic              neg;    // quotient is negative
	} axis_item_t;

	typedef struct packed {
		axis_item_t ax;
		axis_item_t ay;
		logic       inval;
	} front_item_t;

	// one divider lane; nq shifts dividend bits out and quotient bits in
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] nq;
		logic [DEN_W-1:0] den;
		logic             neg;
	} div_lane_t;

	typedef struct packed {
		div_lane_t lx;
		div_lane_t ly;
		logic      inval;
	} div_item_t;

endpackage

// ----- hw/rtl/stripline_bpm_position.sv -----
// stripline_bpm_position: an accepted sample set passes through the queue, the
// 19-stage divider and the 7-stage arithmetic back end to m_tvalid; throughput
// is one item per cycle when the output is not stalled
// s_tready drops only when the 4-entry queue between front and back is full
// reset clears the queue, all pipeline valid bits and loads the default
// configuration; no clearing pass is needed
module stripline_bpm_position (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave stream, tdata: adc_x_plus, adc_x_minus, adc_y_plus, adc_y_minus, zero pad
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bpmpos_pkg::IN_TDATA_W-1:0]    s_tdata,
	// master stream, tdata: pos_x, pos_y; tuser: invalid
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bpmpos_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                                 m_tuser,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [bpmpos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpmpos_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import bpmpos_pkg::*;

	cfg_t         cfg_q;
	front_item_t  push_item, head_item;
	div_item_t    div_item;
	logic         push, q_ready, head_valid, div_valid, adv;
	logic [15:0]  pos_x, pos_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PED_XP:  cfg_q.ped_xp      <= cfg_wdata[PED_W-1:0];
				REG_PED_XM:  cfg_q.ped_xm      <= cfg_wdata[PED_W-1:0];
				REG_PED_YP:  cfg_q.ped_yp      <= cfg_wdata[PED_W-1:0];
				REG_PED_YM:  cfg_q.ped_ym      <= cfg_wdata[PED_W-1:0];
				REG_KAPPA:   cfg_q.kappa       <= cfg_wdata[15:0];
				REG_ATTEN_X: cfg_q.atten_x     <= cfg_wdata[15:0];
				REG_ATTEN_Y: cfg_q.atten_y     <= cfg_wdata[15:0];
				REG_OFFSET:  cfg_q.offset_pair <= cfg_wdata[31:0];
			endcase
		end
	end

	// back end advances whenever the output register is free or drains
	assign adv = !m_tvalid || m_tready;

	bpmpos_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg_q),
		.q_ready  (q_ready),
		.q_push   (push),
		.q_item   (push_item)
	);

	bpmpos_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push),
		.wr_ready (q_ready),
		.wr_item  (push_item),
		.rd_en    (adv),
		.rd_valid (head_valid),
		.rd_item  (head_item)
	);

	bpmpos_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (head_valid),
		.in_item   (head_item),
		.out_valid (div_valid),
		.out_item  (div_item)
	);

	bpmpos_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (div_valid),
		.in_item   (div_item),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.invalid   (m_tuser)
	);

	assign m_tdata = {pos_y, pos_x};

endmodule

// ----- hw/rtl/bpmpos_front.sv -----
// bpmpos_front: pedestal subtraction, difference and sum, zero-sum check
// and kappa product for each incoming sample set
// depends on bpmpos_pkg
module bpmpos_front (
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bpmpos_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  bpmpos_pkg::cfg_t                   cfg,
	input  logic                               q_ready,
	output logic                               q_push,
	output bpmpos_pkg::front_item_t            q_item
);
	import bpmpos_pkg::*;

	logic signed [DIF_W-1:0] sum_x, sum_y;

	// one axis: subtract pedestals, form difference and sum magnitudes, kappa product and sign
	function automatic axis_item_t axis_calc(
		input logic [ADC_BITS-1:0] plus,
		input logic [ADC_BITS-1:0] minus,
		input logic [PED_W-1:0]    ped_p,
		input logic [PED_W-1:0]    ped_m,
		input logic [15:0]         kappa
	);
		logic signed [SMP_W-1:0] sp, sm;
		logic signed [DIF_W-1:0] dif, sum;
		logic [MAG_W-1:0]        dmag;
		axis_item_t              r;
		sp   = $signed({1'b0, plus})  - $signed({1'b0, ADC_BITS'(ped_p)});
		sm   = $signed({1'b0, minus}) - $signed({1'b0, ADC_BITS'(ped_m)});
		dif  = DIF_W'(sp) - DIF_W'(sm);
		sum  = DIF_W'(sp) + DIF_W'(sm);
		dmag = dif[DIF_W-1] ? MAG_W'(-dif) : MAG_W'(dif);
		r.mag  = sum[DIF_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
		r.neg  = dif[DIF_W-1] ^ sum[DIF_W-1];
		r.prod = PROD_W'(kappa) * PROD_W'(dmag);
		return r;
	endfunction

	// axis sums for the zero check
	function automatic logic signed [DIF_W-1:0] axis_sum(
		input logic [ADC_BITS-1:0] plus,
		input logic [ADC_BITS-1:0] minus,
		input logic [PED_W-1:0]    ped_p,
		input logic [PED_W-1:0]    ped_m
	);
		logic signed [SMP_W-1:0] sp, sm;
		sp = $signed({1'b0, plus})  - $signed({1'b0, ADC_BITS'(ped_p)});
		sm = $signed({1'b0, minus}) - $signed({1'b0, ADC_BITS'(ped_m)});
		return DIF_W'(sp) + DIF_W'(sm);
	endfunction

	// classify the item
	always_comb begin
		sum_x = axis_sum(s_tdata[0*ADC_BITS +: ADC_BITS], s_tdata[1*ADC_BITS +: ADC_BITS],
			cfg.ped_xp, cfg.ped_xm);
		sum_y = axis_sum(s_tdata[2*ADC_BITS +: ADC_BITS], s_tdata[3*ADC_BITS +: ADC_BITS],
			cfg.ped_yp, cfg.ped_ym);
		q_item.ax = axis_calc(s_tdata[0*ADC_BITS +: ADC_BITS],
			s_tdata[1*ADC_BITS +: ADC_BITS], cfg.ped_xp, cfg.ped_xm, cfg.kappa);
		q_item.ay = axis_calc(s_tdata[2*ADC_BITS +: ADC_BITS],
			s_tdata[3*ADC_BITS +: ADC_BITS], cfg.ped_yp, cfg.ped_ym, cfg.kappa);
		q_item.inval = (sum_x == '0) || (sum_y == '0);
	end

	// handshake into the queue
	assign s_tready = q_ready;
	assign q_push   = s_tvalid && q_ready;

endmodule

// ----- hw/rtl/bpmpos_fifo.sv -----
// bpmpos_fifo: short register queue between the front and the back
// depends on bpmpos_pkg
module bpmpos_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_valid,
	output logic                     wr_ready,
	input  bpmpos_pkg::front_item_t  wr_item,
	input  logic                     rd_en,
	output logic                     rd_valid,
	output bpmpos_pkg::front_item_t  rd_item
);
	import bpmpos_pkg::*;

	front_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 push, pop;

	assign wr_ready = (count_q != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_en && rd_valid;
	assign rd_item  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue fill count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone write");

endmodule

// ----- hw/rtl/bpmpos_div.sv -----
// bpmpos_div: pipelined restoring divider for both axes, two quotient bits
// per stage, rounding folded into the dividend
// depends on bpmpos_pkg
module bpmpos_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  bpmpos_pkg::front_item_t  in_item,
	output logic                     out_valid,
	output bpmpos_pkg::div_item_t    out_item
);
	import bpmpos_pkg::*;

	div_item_t            stage_s [DIV_STAGES+1];
	logic [DIV_STAGES:0]  vld_s;

	// dividend 32*prod + |sum| over divisor 2*|sum| gives the rounded quotient
	function automatic div_lane_t lane_prep(input axis_item_t a);
		div_lane_t r;
		r.rem = '0;
		r.nq  = NUM_W'({a.prod, 5'b0}) + NUM_W'(a.mag);
		r.den = {a.mag, 1'b0};
		r.neg = a.neg;
		return r;
	endfunction

	// two restoring steps
	function automatic div_lane_t lane_step(input div_lane_t l);
		logic [DEN_W:0]   sh;
		logic [NUM_W-1:0] nq;
		logic [DEN_W-1:0] rem;
		rem = l.rem;
		nq  = l.nq;
		for (int i = 0; i < 2; i++) begin
			sh = {rem, nq[NUM_W-1]};
			nq = {nq[NUM_W-2:0], 1'b0};
			if (sh >= {1'b0, l.den}) begin
				sh    = sh - {1'b0, l.den};
				nq[0] = 1'b1;
			end
			rem = sh[DEN_W-1:0];
		end
		return '{rem: rem, nq: nq, den: l.den, neg: l.neg};
	endfunction

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_STAGES-1:0], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s[0].lx    <= lane_prep(in_item.ax);
			stage_s[0].ly    <= lane_prep(in_item.ay);
			stage_s[0].inval <= in_item.inval;
			for (int k = 1; k <= DIV_STAGES; k++) begin
				stage_s[k].lx    <= lane_step(stage_s[k-1].lx);
				stage_s[k].ly    <= lane_step(stage_s[k-1].ly);
				stage_s[k].inval <= stage_s[k-1].inval;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign out_item  = stage_s[DIV_STAGES];

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("divider pipeline moved while stalled");

endmodule

// ----- hw/rtl/bpmpos_post.sv -----
// bpmpos_post: sign, 45 degree rotation, attenuation, 1/sqrt(2) scale,
// offsets, rounding and saturation, ending in the output register
// depends on bpmpos_pkg
module bpmpos_post (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  bpmpos_pkg::div_item_t  in_item,
	input  bpmpos_pkg::cfg_t       cfg,
	output logic                   out_valid,
	output logic [15:0]            pos_x,
	output logic [15:0]            pos_y,
	output logic                   invalid
);
	import bpmpos_pkg::*;

	localparam logic signed [PA_W-1:0] TX_HI  = PA_W'(TC_MAX);
	localparam logic signed [PA_W-1:0] TX_LO  = PA_W'(-TC_MAX - 1);
	localparam logic signed [WO_W-1:0] SAT_HI = WO_W'(32767);
	localparam logic signed [WO_W-1:0] SAT_LO = WO_W'(-32768);

	logic [6:1]                vld_s;
	logic [6:1]                inv_s;
	logic signed [SUM_W-1:0]   dif_s1, sum_s1;
	logic signed [PA_W-1:0]    px_s2, py_s2;
	logic signed [TC_W-1:0]    tx_s3, ty_s3;
	logic signed [MS_W-1:0]    mx_s4, my_s4;
	logic signed [T2_W-1:0]    tx_s5, ty_s5;
	logic signed [WO_W-1:0]    wx_s6, wy_s6;
	logic                      out_valid_q, invalid_q;
	logic [15:0]               pos_x_q, pos_y_q;

	logic signed [XR_W-1:0]    xr, yr;
	logic signed [15:0]        offx, offy;
	logic [PA_W-1:0]           r14x, r14y;
	logic signed [PA_W-1:0]    sh14x, sh14y;
	logic [MS_W-1:0]           r16x, r16y;
	logic signed [MS_W-1:0]    sh16x, sh16y;
	logic [WO_W-1:0]           r4x, r4y;
	logic signed [WO_W-1:0]    sh4x, sh4y;

	// signed quotients
	assign xr = in_item.lx.neg ? -$signed({1'b0, in_item.lx.nq}) : $signed({1'b0, in_item.lx.nq});
	assign yr = in_item.ly.neg ? -$signed({1'b0, in_item.ly.nq}) : $signed({1'b0, in_item.ly.nq});

	assign offx = $signed(cfg.offset_pair[15:0]);
	assign offy = $signed(cfg.offset_pair[31:16]);

	// rounding shifts, half away from zero
	always_comb begin
		r14x  = px_s2 + PA_W'(2 ** 13) - PA_W'(px_s2[PA_W-1]);
		r14y  = py_s2 + PA_W'(2 ** 13) - PA_W'(py_s2[PA_W-1]);
		sh14x = $signed(r14x) >>> 14;
		sh14y = $signed(r14y) >>> 14;
		r16x  = mx_s4 + MS_W'(2 ** 15) - MS_W'(mx_s4[MS_W-1]);
		r16y  = my_s4 + MS_W'(2 ** 15) - MS_W'(my_s4[MS_W-1]);
		sh16x = $signed(r16x) >>> 16;
		sh16y = $signed(r16y) >>> 16;
		r4x   = wx_s6 + WO_W'(8) - WO_W'(wx_s6[WO_W-1]);
		r4y   = wy_s6 + WO_W'(8) - WO_W'(wy_s6[WO_W-1]);
		sh4x  = $signed(r4x) >>> 4;
		sh4y  = $signed(r4y) >>> 4;
	end

	// control: valid bits and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[5:1], in_valid};
			out_valid_q <= vld_s[6];
		end
	end

	// arithmetic pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s <= {inv_s[5:1], in_item.inval};
			// rotate by 45 degrees
			dif_s1 <= SUM_W'(xr) - SUM_W'(yr);
			sum_s1 <= SUM_W'(xr) + SUM_W'(yr);
			// attenuation
			px_s2 <= dif_s1 * $signed({1'b0, cfg.atten_x});
			py_s2 <= sum_s1 * $signed({1'b0, cfg.atten_y});
			// back to Q.12, clamped where the output saturates anyway
			if (sh14x > TX_HI)      tx_s3 <= TC_W'(TX_HI);
			else if (sh14x < TX_LO) tx_s3 <= TC_W'(TX_LO);
			else                    tx_s3 <= TC_W'(sh14x);
			if (sh14y > TX_HI)      ty_s3 <= TC_W'(TX_HI);
			else if (sh14y < TX_LO) ty_s3 <= TC_W'(TX_LO);
			else                    ty_s3 <= TC_W'(sh14y);
			// 1/sqrt(2)
			mx_s4 <= tx_s3 * $signed({1'b0, INV_SQRT2_Q16});
			my_s4 <= ty_s3 * $signed({1'b0, INV_SQRT2_Q16});
			tx_s5 <= T2_W'(sh16x);
			ty_s5 <= T2_W'(sh16y);
			// offsets in Q.12, negated for x
			wx_s6 <= WO_W'(tx_s5) - (WO_W'(offx) <<< 4);
			wy_s6 <= WO_W'(ty_s5) + (WO_W'(offy) <<< 4);
			// Q8.8 with saturation, zero for an invalid item
			invalid_q <= inv_s[6];
			if (inv_s[6])          pos_x_q <= '0;
			else if (sh4x > SAT_HI) pos_x_q <= 16'(SAT_HI);
			else if (sh4x < SAT_LO) pos_x_q <= 16'(SAT_LO);
			else                    pos_x_q <= 16'(sh4x);
			if (inv_s[6])          pos_y_q <= '0;
			else if (sh4y > SAT_HI) pos_y_q <= 16'(SAT_HI);
			else if (sh4y < SAT_LO) pos_y_q <= 16'(SAT_LO);
			else                    pos_y_q <= 16'(sh4y);
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign invalid   = invalid_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && invalid_q |-> (pos_x_q == '0) && (pos_y_q == '0))
		else $error("invalid item carries a nonzero position");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(out_valid_q) && $stable(vld_s))
		else $error("back pipeline moved while stalled");

endmodule
